// File: src/tcts_pkg.sv
// ----------------------------------------------------------------------------
// tcts_pkg: shared types and constants of the ticket scheduler
// Sizes, class and status codes, channel widths and FIFO handshake structs.
// ----------------------------------------------------------------------------
package tcts_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int TICKET_BITS = 16;

    localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_BITS = PTR_BITS + 1;

    localparam int NUM_CLASSES = 3;
    localparam int CLASS_BITS  = 2;
    localparam int STATUS_BITS = 2;
    localparam int RATIO_BITS  = 4;
    localparam int RUN_BITS    = 4;

    localparam logic [RUN_BITS-1:0]   RUN_MAX     = 4'd15;
    localparam logic [RATIO_BITS-1:0] RATIO_RESET = 4'd3;

    // client classes
    localparam logic [CLASS_BITS-1:0] CLS_PRIORITY = 2'd0;
    localparam logic [CLASS_BITS-1:0] CLS_POSTAL   = 2'd1;
    localparam logic [CLASS_BITS-1:0] CLS_MONEY    = 2'd2;
    localparam logic [CLASS_BITS-1:0] CLS_NONE     = 2'd3;

    // result status codes
    localparam logic [STATUS_BITS-1:0] ST_QUEUED  = 2'd0;
    localparam logic [STATUS_BITS-1:0] ST_SERVED  = 2'd1;
    localparam logic [STATUS_BITS-1:0] ST_EMPTY   = 2'd2;
    localparam logic [STATUS_BITS-1:0] ST_FULL    = 2'd3;

    // opcodes
    localparam logic OP_ENQUEUE = 1'b0;
    localparam logic OP_SERVE   = 1'b1;

    // register map
    localparam int  CFG_ADDR_BITS  = 3;
    localparam int  CFG_DATA_BITS  = 32;
    localparam logic REG_MONEY_RATIO = 1'b0;

    // stream widths
    localparam int IN_TDATA_BITS  = 8;
    localparam int IN_TUSER_BITS  = 1;
    localparam int OUT_TDATA_BITS = ((TICKET_BITS + CLASS_BITS + 7) / 8) * 8;
    localparam int OUT_TUSER_BITS = STATUS_BITS;

    typedef struct packed {
        logic push;
        logic pop;
    } t_fifo_ctl;

    typedef struct packed {
        logic empty;
        logic full;
    } t_fifo_sts;

endpackage

// File: src/tcts_fifo.sv
// ----------------------------------------------------------------------------
// tcts_fifo: ticket FIFO for one client class
// Circular store with head pointer and fill count; head word kept in a register.
// ----------------------------------------------------------------------------
module tcts_fifo (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  tcts_pkg::t_fifo_ctl              i_ctl,
    input  logic [tcts_pkg::TICKET_BITS-1:0] i_push_data,
    output logic [tcts_pkg::TICKET_BITS-1:0] o_head_data,
    output tcts_pkg::t_fifo_sts              o_sts
);

    localparam logic [tcts_pkg::CNT_BITS-1:0] DEPTH_C =
        tcts_pkg::CNT_BITS'(tcts_pkg::QUEUE_DEPTH);
    localparam logic [tcts_pkg::PTR_BITS-1:0] LAST_C =
        tcts_pkg::PTR_BITS'(tcts_pkg::QUEUE_DEPTH - 1);

    logic [tcts_pkg::TICKET_BITS-1:0] r_store [tcts_pkg::QUEUE_DEPTH];
    logic [tcts_pkg::TICKET_BITS-1:0] r_head_data;
    logic [tcts_pkg::PTR_BITS-1:0]    r_head, n_head;
    logic [tcts_pkg::CNT_BITS-1:0]    r_count, n_count;
    logic [tcts_pkg::CNT_BITS-1:0]    w_tail_sum;
    logic [tcts_pkg::PTR_BITS-1:0]    w_tail;

    // wrap tail = head + count back into the store
    assign w_tail_sum = {1'b0, r_head} + r_count;
    assign w_tail = (w_tail_sum >= DEPTH_C) ?
                    tcts_pkg::PTR_BITS'(w_tail_sum - DEPTH_C) :
                    w_tail_sum[tcts_pkg::PTR_BITS-1:0];

    assign o_head_data = r_head_data;
    assign o_sts.empty = (r_count == '0);
    assign o_sts.full  = (r_count >= DEPTH_C);

    always_comb begin
        n_head  = r_head;
        n_count = r_count;
        if (i_ctl.pop) begin
            n_head  = (r_head == LAST_C) ? '0 : r_head + 1'b1;
            n_count = r_count - 1'b1;
        end else if (i_ctl.push) begin
            n_count = r_count + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_count <= '0;
        end else begin
            r_head  <= n_head;
            r_count <= n_count;
        end
    end

    // a push into an empty queue lands straight in the head register;
    // a pop that leaves words behind loads the next one from the store
    always_ff @(posedge i_clk) begin
        if (i_ctl.push) begin
            r_store[w_tail] <= i_push_data;
        end
        if (i_ctl.push && (r_count == '0)) begin
            r_head_data <= i_push_data;
        end else if (i_ctl.pop && (n_count != '0)) begin
            r_head_data <= r_store[n_head];
        end
    end

endmodule

// File: src/three_class_ticket_scheduler_core.sv
// ----------------------------------------------------------------------------
// three_class_ticket_scheduler_core: three-queue ticket dispenser and server
// Hands out ticket numbers into priority, postal and money queues and serves
// them by strict priority plus a money/postal ratio.
// ----------------------------------------------------------------------------
//
// Channel   Dir  Word                          Notes
// s_axis    in   tuser[0] opcode               0 enqueue, 1 serve
//                tdata[1:0] client_class       used on enqueue only
// m_axis    out  tuser[1:0] status             queued/served/empty/full
//                tdata[15:0] ticket, [17:16] served_class
// apb       in   reg 0 (addr 0) money_ratio    4 bits, reset 3
//
// One word is accepted per cycle and one result word leaves per cycle while
// m_axis is not stalled; a word passes the input register, then the result
// register. The rate is set by the single decide-and-update pass on the FIFO
// heads and counters. Reset clears all pointers, the ticket counter and the
// money run; the ticket stores need no clearing. A stalled result holds in
// the result register while the input register still takes one more word.
// ----------------------------------------------------------------------------
module three_class_ticket_scheduler_core (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // stream in
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [tcts_pkg::IN_TDATA_BITS-1:0]   s_axis_tdata,  // [1:0] client_class
    input  logic [tcts_pkg::IN_TUSER_BITS-1:0]   s_axis_tuser,  // [0] opcode
    // stream out
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    output logic [tcts_pkg::OUT_TDATA_BITS-1:0]  m_axis_tdata,  // ticket, served_class
    output logic [tcts_pkg::OUT_TUSER_BITS-1:0]  m_axis_tuser,  // [1:0] status
    // configuration
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [tcts_pkg::CFG_ADDR_BITS-1:0]   paddr,
    input  logic [tcts_pkg::CFG_DATA_BITS-1:0]   pwdata,
    output logic [tcts_pkg::CFG_DATA_BITS-1:0]   prdata,
    output logic                                 pready
);

    localparam int TB = tcts_pkg::TICKET_BITS;
    localparam int CB = tcts_pkg::CLASS_BITS;

    // ---------------- configuration ----------------
    logic [tcts_pkg::RATIO_BITS-1:0] r_ratio;
    logic                            w_reg_sel;

    assign pready    = 1'b1;
    assign w_reg_sel = (paddr[2] == tcts_pkg::REG_MONEY_RATIO);
    assign prdata    = w_reg_sel ?
                       {{(tcts_pkg::CFG_DATA_BITS-tcts_pkg::RATIO_BITS){1'b0}}, r_ratio} :
                       '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ratio <= tcts_pkg::RATIO_RESET;
        end else if (psel && penable && pwrite && pready && w_reg_sel) begin
            r_ratio <= pwdata[tcts_pkg::RATIO_BITS-1:0];
        end
    end

    // ---------------- input register ----------------
    logic                    r_in_valid;
    logic                    r_in_op;
    logic [CB-1:0]           r_in_cls;
    logic                    w_proc;
    logic                    w_out_free;

    assign w_out_free    = !m_axis_tvalid || m_axis_tready;
    assign w_proc        = r_in_valid && w_out_free;
    assign s_axis_tready = !r_in_valid || w_out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_op  <= s_axis_tuser[0];
            r_in_cls <= s_axis_tdata[CB-1:0];
        end
    end

    // ---------------- class FIFOs ----------------
    tcts_pkg::t_fifo_ctl w_ctl  [tcts_pkg::NUM_CLASSES];
    tcts_pkg::t_fifo_sts w_sts  [tcts_pkg::NUM_CLASSES];
    logic [TB-1:0]       w_head [tcts_pkg::NUM_CLASSES];

    logic [TB-1:0]       r_next_ticket;
    logic [tcts_pkg::RUN_BITS-1:0] r_run, n_run;

    genvar g;
    generate
        for (g = 0; g < tcts_pkg::NUM_CLASSES; g++) begin : g_fifo
            tcts_fifo u_fifo (
                .i_clk       (i_clk),
                .i_rst_n     (i_rst_n),
                .i_ctl       (w_ctl[g]),
                .i_push_data (r_next_ticket),
                .o_head_data (w_head[g]),
                .o_sts       (w_sts[g])
            );
        end
    endgenerate

    // ---------------- decide ----------------
    logic [tcts_pkg::STATUS_BITS-1:0] w_status;
    logic [TB-1:0]                    w_ticket;
    logic [CB-1:0]                    w_class;
    logic                             w_push;
    logic                             w_pop;
    logic                             w_enq_ok;

    always_comb begin
        w_status = tcts_pkg::ST_EMPTY;
        w_ticket = '0;
        w_class  = tcts_pkg::CLS_PRIORITY;
        w_push   = 1'b0;
        w_pop    = 1'b0;
        w_enq_ok = 1'b0;
        n_run    = r_run;

        if (r_in_op == tcts_pkg::OP_ENQUEUE) begin
            w_class = r_in_cls;
            case (r_in_cls)
                tcts_pkg::CLS_PRIORITY: w_enq_ok = !w_sts[0].full;
                tcts_pkg::CLS_POSTAL:   w_enq_ok = !w_sts[1].full;
                tcts_pkg::CLS_MONEY:    w_enq_ok = !w_sts[2].full;
                default:                w_enq_ok = 1'b0;
            endcase
            if (w_enq_ok) begin
                w_status = tcts_pkg::ST_QUEUED;
                w_ticket = r_next_ticket;
                w_push   = 1'b1;
            end else begin
                w_status = tcts_pkg::ST_FULL;
            end
        end else begin
            w_status = tcts_pkg::ST_SERVED;
            w_pop    = 1'b1;
            if (!w_sts[0].empty) begin
                w_class = tcts_pkg::CLS_PRIORITY;
            end else if (w_sts[2].empty && !w_sts[1].empty) begin
                w_class = tcts_pkg::CLS_POSTAL;
            end else if (!w_sts[2].empty) begin
                // let one waiting postal client in once the money run is long enough
                if (!w_sts[1].empty && (r_run >= r_ratio)) begin
                    w_class = tcts_pkg::CLS_POSTAL;
                    n_run   = '0;
                end else begin
                    w_class = tcts_pkg::CLS_MONEY;
                    if (r_run < tcts_pkg::RUN_MAX) begin
                        n_run = r_run + 1'b1;
                    end
                end
            end else begin
                w_status = tcts_pkg::ST_EMPTY;
                w_pop    = 1'b0;
            end
            case (w_class)
                tcts_pkg::CLS_PRIORITY: w_ticket = w_pop ? w_head[0] : '0;
                tcts_pkg::CLS_POSTAL:   w_ticket = w_pop ? w_head[1] : '0;
                tcts_pkg::CLS_MONEY:    w_ticket = w_pop ? w_head[2] : '0;
                default:                w_ticket = '0;
            endcase
        end
    end

    always_comb begin
        for (int c = 0; c < tcts_pkg::NUM_CLASSES; c++) begin
            w_ctl[c].push = w_proc && w_push && (w_class == CB'(c));
            w_ctl[c].pop  = w_proc && w_pop  && (w_class == CB'(c));
        end
    end

    // ---------------- state and result register ----------------
    logic [tcts_pkg::STATUS_BITS-1:0] r_status;
    logic [TB-1:0]                    r_ticket;
    logic [CB-1:0]                    r_class;
    logic                             r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_next_ticket <= '0;
            r_run         <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (w_proc) begin
                r_run <= n_run;
                if (w_push) begin
                    r_next_ticket <= r_next_ticket + 1'b1;
                end
            end
            if (w_out_free) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_proc) begin
            r_status <= w_status;
            r_ticket <= w_ticket;
            r_class  <= w_class;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_status;
    assign m_axis_tdata  = {{(tcts_pkg::OUT_TDATA_BITS-TB-CB){1'b0}}, r_class, r_ticket};

endmodule
